[src/urlpd_pkg.sv]
// Package for the URL path percent-decode checker: character codes, the
// escape phase type and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urlpd_pkg;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

    localparam logic [1:0] SEG_LEN_MAX = 2'd3;
    localparam logic [1:0] SEG_LEN_DOTS_MAX = 2'd2;

    typedef enum logic [2:0] {
        PH_TEXT = 3'b001,
        PH_HEX1 = 3'b010,
        PH_HEX2 = 3'b100
    } escape_phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        logic [7:0] diff;
        r    = '{ok: 1'b0, value: 4'd0};
        diff = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            diff = c - CH_ZERO;
            r    = '{ok: 1'b1, value: diff[3:0]};
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            diff = c - CH_UPPER_A + HEX_LETTER_BASE;
            r    = '{ok: 1'b1, value: diff[3:0]};
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            diff = c - CH_LOWER_A + HEX_LETTER_BASE;
            r    = '{ok: 1'b1, value: diff[3:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/url_path_percent_decode_check.sv]
// Top level of the URL path percent-decode checker.
// Depends on urlpd_pkg for character codes, the phase type and hex decoding.
//
// The block takes one raw path character per item and returns one result per
// item: an optional decoded byte, a segment-end mark and, on the last character,
// an accept or reject verdict. It accepts a new item in every cycle while the
// output side is not stalled; each item passes an input register and then a
// result register, and the result is presented when it enters the result
// register and held until the output side takes it. The per-path state is
// updated as an item moves into the result register, and it returns to its
// reset value after the item marked last, ready for the next path.
`timescale 1ns / 1ps
`default_nettype none

module url_path_percent_decode_check
    import urlpd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    input  wire logic       s_is_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_byte_out,
    output logic            m_byte_valid,
    output logic            m_segment_end,
    output logic            m_done_res,
    output logic            m_verdict
);

    logic          in_valid_reg;
    logic [7:0]    char_reg;
    logic          last_reg;
    logic          out_valid_reg;
    logic [7:0]    byte_out_reg;
    logic          byte_valid_reg;
    logic          segment_end_reg;
    logic          done_reg;
    logic          verdict_reg;

    escape_phase_t phase_reg, phase_next;
    logic [3:0]    high_nibble_reg, high_nibble_next;
    logic          leading_reg, leading_next;
    logic [1:0]    seg_len_reg, seg_len_next;
    logic          all_dots_reg, all_dots_next;
    logic          rejected_reg, rejected_next;

    logic          out_free;
    logic          advance;
    logic [7:0]    res_byte;
    logic          res_byte_valid;
    logic          res_segment_end;
    logic          res_verdict;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    always_comb begin
        hex_digit_t hd;
        logic       have_byte;
        logic       from_escape;
        logic [7:0] d;
        logic       rej;
        logic       seg_bad;
        escape_phase_t ph;
        logic [3:0] hn;
        logic       lead;
        logic [1:0] len;
        logic       dots;

        hd          = hex_decode(char_reg);
        have_byte   = 1'b0;
        from_escape = 1'b0;
        d           = 8'd0;
        rej         = rejected_reg;
        ph          = phase_reg;
        hn          = high_nibble_reg;
        lead        = leading_reg;
        len         = seg_len_reg;
        dots        = all_dots_reg;
        seg_bad     = 1'b0;
        res_byte        = 8'd0;
        res_byte_valid  = 1'b0;
        res_segment_end = 1'b0;

        if (!rejected_reg) begin
            unique case (phase_reg)
                PH_HEX1: begin
                    if (hd.ok) begin
                        hn = hd.value;
                        ph = PH_HEX2;
                    end else begin
                        rej = 1'b1;
                    end
                end
                PH_HEX2: begin
                    if (hd.ok) begin
                        d  = {high_nibble_reg, hd.value};
                        ph = PH_TEXT;
                        if (d == CH_NUL || d == CH_SLASH || d == CH_BACKSLASH) begin
                            rej = 1'b1;
                        end else begin
                            have_byte   = 1'b1;
                            from_escape = 1'b1;
                        end
                    end else begin
                        rej = 1'b1;
                    end
                end
                default: begin
                    ph = PH_TEXT;
                    if (char_reg == CH_NUL || char_reg == CH_BACKSLASH) begin
                        rej = 1'b1;
                    end else if (char_reg == CH_PERCENT) begin
                        ph = PH_HEX1;
                    end else begin
                        d         = char_reg;
                        have_byte = 1'b1;
                    end
                end
            endcase

            seg_bad = (seg_len_reg == 2'd0)
                   || (all_dots_reg && seg_len_reg <= SEG_LEN_DOTS_MAX);

            if (have_byte) begin
                if (!from_escape && d == CH_SLASH) begin
                    if (!leading_reg) begin
                        if (seg_bad) begin
                            rej = 1'b1;
                        end else begin
                            res_segment_end = 1'b1;
                            len  = 2'd0;
                            dots = 1'b1;
                        end
                    end
                end else begin
                    lead           = 1'b0;
                    res_byte       = d;
                    res_byte_valid = 1'b1;
                    if (seg_len_reg != SEG_LEN_MAX) begin
                        len = seg_len_reg + 2'd1;
                    end
                    if (d != CH_DOT) begin
                        dots = 1'b0;
                    end
                end
            end

            if (last_reg && !rej) begin
                if (ph != PH_TEXT || lead || len == 2'd0
                        || (dots && len <= SEG_LEN_DOTS_MAX)) begin
                    rej = 1'b1;
                end
            end
        end

        res_verdict = last_reg && rej;

        if (last_reg) begin
            phase_next       = PH_TEXT;
            high_nibble_next = 4'd0;
            leading_next     = 1'b1;
            seg_len_next     = 2'd0;
            all_dots_next    = 1'b1;
            rejected_next    = 1'b0;
        end else begin
            phase_next       = ph;
            high_nibble_next = hn;
            leading_next     = lead;
            seg_len_next     = len;
            all_dots_next    = dots;
            rejected_next    = rej;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_TEXT;
            high_nibble_reg <= 4'd0;
            leading_reg     <= 1'b1;
            seg_len_reg     <= 2'd0;
            all_dots_reg    <= 1'b1;
            rejected_reg    <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                phase_reg       <= phase_next;
                high_nibble_reg <= high_nibble_next;
                leading_reg     <= leading_next;
                seg_len_reg     <= seg_len_next;
                all_dots_reg    <= all_dots_next;
                rejected_reg    <= rejected_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_in;
            last_reg <= s_is_last;
        end
        if (advance) begin
            byte_out_reg    <= res_byte;
            byte_valid_reg  <= res_byte_valid;
            segment_end_reg <= res_segment_end;
            done_reg        <= last_reg;
            verdict_reg     <= res_verdict;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_byte_out    = byte_out_reg;
    assign m_byte_valid  = byte_valid_reg;
    assign m_segment_end = segment_end_reg;
    assign m_done_res    = done_reg;
    assign m_verdict     = verdict_reg;

endmodule

`default_nettype wire
